// ----- design/edf_pkg.sv -----
// Shared types, widths and constants for the EDF slice scheduler.
`default_nettype none
package edf_pkg;

   localparam int MAX_TASKS_DEF = 8;
   localparam int TIME_W = 48;
   localparam int PER_W = 30;
   localparam int UTIL_W = 10;
   localparam int LIMIT_W = 7;
   localparam int ID_W = 3;
   localparam int MISS_OUT_W = 4;
   localparam logic [LIMIT_W-1:0] PCT_SCALE = 7'd100;
   localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd80;
   localparam logic OP_ACTIVATE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   typedef struct packed {
      logic              opcode;
      logic [ID_W-1:0]   task_id;
      logic [PER_W-1:0]  period_len;
      logic [PER_W-1:0]  slice_us;
      logic [TIME_W-1:0] now_us;
   } req_type;

   typedef struct packed {
      logic                  admitted;
      logic                  run_valid;
      logic [ID_W-1:0]       run_task;
      logic                  switch_needed;
      logic [MISS_OUT_W-1:0] missed_count;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_ACT_CHK,
      S_SHARE_WAIT,
      S_BND_WAIT,
      S_BND,
      S_UNIQ,
      S_ACT_WR,
      S_FIRST_SCAN,
      S_FIRST_SET,
      S_CHG_DIFF,
      S_CHG_ADD,
      S_REN_CHK,
      S_MISS_SCAN,
      S_PICK_SCAN,
      S_PICK_DONE,
      S_REN_START,
      S_REN_WR,
      S_SEL_SCAN,
      S_SEL_DONE,
      S_RESP
   } seq_state_type;

endpackage
`default_nettype wire

// ----- design/edf_div.sv -----
// Restoring divider, one quotient bit per cycle: time value by a period.
`default_nettype none
module edf_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [edf_pkg::TIME_W-1:0] dividend,
   input  wire logic [edf_pkg::PER_W-1:0]  divisor,
   output logic                            done,
   output logic [edf_pkg::TIME_W-1:0]      quotient,
   output logic [edf_pkg::PER_W-1:0]       remainder
);
   import edf_pkg::*;

   localparam int CNT_W = $clog2(TIME_W + 1);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TIME_W - 1);

   logic               run_ff, run_in;
   logic               done_ff, done_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [TIME_W-1:0]  q_ff, q_in;
   logic [PER_W-1:0]   r_ff, r_in;
   logic [PER_W-1:0]   dv_ff, dv_in;
   logic [PER_W:0]     shifted;
   logic               ge;

   assign shifted = {r_ff, q_ff[TIME_W-1]};
   assign ge = shifted >= {1'b0, dv_ff};

   always_comb begin
      run_in = run_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      q_in = q_ff;
      r_in = r_ff;
      dv_in = dv_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         q_in = dividend;
         r_in = '0;
         dv_in = divisor;
      end else if (run_ff) begin
         q_in = {q_ff[TIME_W-2:0], ge};
         r_in = ge ? PER_W'(shifted - {1'b0, dv_ff}) : shifted[PER_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_LAST) begin
            run_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      dv_ff <= dv_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = r_ff;

endmodule
`default_nettype wire

// ----- design/edf_slice_scheduler.sv -----
// Top level: EDF task table, scan sequencer and shared divider.
`default_nettype none
// EDF slice scheduler. Pulse start with an item while busy is low; busy stays high
// until the result is shown for one cycle on rsp_data with rsp_strobe, which the
// receiver must take then. Entries are walked one per cycle through a single compare
// unit, and period arithmetic uses a 48-step restoring divider. The result strobe
// follows in the cycle after the last busy cycle, as busy falls. The utilization
// limit is written only while busy is low; csr_ready follows !busy.
module edf_slice_scheduler #(
   parameter int MAX_TASKS = edf_pkg::MAX_TASKS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire edf_pkg::req_type            req_data,
   output logic                             rsp_strobe,
   output edf_pkg::rsp_type                 rsp_data,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [edf_pkg::LIMIT_W-1:0] csr_wdata
);
   import edf_pkg::*;

   localparam int IDX_W = $clog2(MAX_TASKS);
   localparam int RND_W = $clog2(MAX_TASKS + 1);
   localparam int MISS_W = $clog2(MAX_TASKS + 1);
   localparam int SUM_W = TIME_W + 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
   localparam logic [RND_W-1:0] LAST_RND = RND_W'(MAX_TASKS);

   // task table
   logic               valid_ff [MAX_TASKS];
   logic [PER_W-1:0]   period_ff [MAX_TASKS];
   logic [PER_W-1:0]   slice_ff [MAX_TASKS];
   logic [TIME_W-1:0]  dl_ff [MAX_TASKS];
   logic [TIME_W-1:0]  used_ff [MAX_TASKS];
   logic [TIME_W-1:0]  wake_ff [MAX_TASKS];
   logic               any_valid;

   // sequencer state
   seq_state_type      st_ff, st_in;
   req_type            req_ff, req_in;
   logic               idok_ff, idok_in;
   logic [IDX_W-1:0]   tgt_ff, tgt_in;
   logic [IDX_W-1:0]   scan_ff, scan_in;
   logic [IDX_W-1:0]   best_ff, best_in;
   logic               bestv_ff, bestv_in;
   logic [TIME_W-1:0]  bdl_ff, bdl_in;
   logic [TIME_W-1:0]  d_ff, d_in;
   logic               clash_ff, clash_in;
   logic [RND_W-1:0]   round_ff, round_in;
   logic [MAX_TASKS-1:0] pend_ff, pend_in;
   logic [MISS_W-1:0]  miss_ff, miss_in;
   logic               ren_ff, ren_in;
   logic               admit_ff, admit_in;
   logic [TIME_W-1:0]  diff_ff, diff_in;
   logic [PER_W-1:0]   per_ff, per_in;
   logic [UTIL_W-1:0]  unx_ff, unx_in;
   logic               selv_ff, selv_in;
   logic [UTIL_W-1:0]  util_ff, util_in;
   logic [PER_W-1:0]   short_ff, short_in;
   logic [TIME_W-1:0]  lchk_ff, lchk_in;
   logic [IDX_W-1:0]   cur_ff, cur_in;
   logic               curv_ff, curv_in;
   logic               idle_ff, idle_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   rsp_type            rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   // table write controls
   logic               wr_act, wr_used_zero, wr_used_add, wr_dl, wr_wake;

   // single read port
   logic [IDX_W-1:0]   rd_idx;
   logic               rd_valid;
   logic [PER_W-1:0]   rd_period;
   logic [PER_W-1:0]   rd_slice;
   logic [TIME_W-1:0]  rd_dl;
   logic [TIME_W-1:0]  rd_used;
   logic [TIME_W-1:0]  rd_wake;
   logic               rd_budget;

   // shared comparator
   logic [TIME_W-1:0]  cmp_a, cmp_b;
   logic               cmp_lt, cmp_eq;

   // divider
   logic               div_start, div_done;
   logic [TIME_W-1:0]  div_dvd, div_quot;
   logic [PER_W-1:0]   div_dvs, div_rem;

   logic               scan_last;
   logic               clash_acc;

   edf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dvd),
      .divisor   (div_dvs),
      .done      (div_done),
      .quotient  (div_quot),
      .remainder (div_rem)
   );

   always_comb begin
      any_valid = 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
         any_valid = any_valid | valid_ff[i];
      end
   end

   always_comb begin
      unique case (st_ff)
         S_UNIQ, S_FIRST_SCAN, S_MISS_SCAN, S_PICK_SCAN, S_SEL_SCAN: rd_idx = scan_ff;
         default: rd_idx = tgt_ff;
      endcase
   end

   assign rd_valid = valid_ff[rd_idx];
   assign rd_period = period_ff[rd_idx];
   assign rd_slice = slice_ff[rd_idx];
   assign rd_dl = dl_ff[rd_idx];
   assign rd_used = used_ff[rd_idx];
   assign rd_wake = wake_ff[rd_idx];
   assign rd_budget = rd_used < TIME_W'(rd_slice);

   always_comb begin
      unique case (st_ff)
         S_FIRST_SCAN, S_SEL_SCAN: begin
            cmp_a = rd_dl;
            cmp_b = bdl_ff;
         end
         S_PICK_SCAN: begin
            cmp_a = bdl_ff;
            cmp_b = rd_dl;
         end
         S_MISS_SCAN: begin
            cmp_a = rd_dl;
            cmp_b = req_ff.now_us;
         end
         default: begin
            cmp_a = rd_dl;
            cmp_b = d_ff;
         end
      endcase
   end

   assign cmp_lt = cmp_a < cmp_b;
   assign cmp_eq = cmp_a == cmp_b;
   assign scan_last = scan_ff == LAST_IDX;
   assign clash_acc = clash_ff | ((scan_ff != tgt_ff) && rd_valid && cmp_eq);

   always_comb begin
      st_in = st_ff;
      req_in = req_ff;
      idok_in = idok_ff;
      tgt_in = tgt_ff;
      scan_in = scan_ff;
      best_in = best_ff;
      bestv_in = bestv_ff;
      bdl_in = bdl_ff;
      d_in = d_ff;
      clash_in = clash_ff;
      round_in = round_ff;
      pend_in = pend_ff;
      miss_in = miss_ff;
      ren_in = ren_ff;
      admit_in = admit_ff;
      diff_in = diff_ff;
      per_in = per_ff;
      unx_in = unx_ff;
      selv_in = selv_ff;
      util_in = util_ff;
      short_in = short_ff;
      lchk_in = lchk_ff;
      cur_in = cur_ff;
      curv_in = curv_ff;
      idle_in = idle_ff;
      limit_in = limit_ff;
      rsp_in = rsp_ff;
      strobe_in = 1'b0;
      wr_act = 1'b0;
      wr_used_zero = 1'b0;
      wr_used_add = 1'b0;
      wr_dl = 1'b0;
      wr_wake = 1'b0;
      div_start = 1'b0;
      div_dvd = req_ff.now_us;
      div_dvs = per_ff;

      if (csr_valid && csr_ready) begin
         limit_in = csr_wdata;
      end

      unique case (st_ff)
         S_IDLE: begin
            if (start) begin
               req_in = req_data;
               idok_in = 32'(req_data.task_id) < MAX_TASKS;
               tgt_in = IDX_W'(req_data.task_id);
               admit_in = 1'b0;
               ren_in = 1'b0;
               selv_in = 1'b0;
               miss_in = '0;
               st_in = (req_data.opcode == OP_ACTIVATE) ? S_ACT_CHK : S_CHG_DIFF;
            end
         end
         S_ACT_CHK: begin
            if (idok_ff && !rd_valid && (req_ff.period_len != '0)) begin
               div_start = 1'b1;
               div_dvd = TIME_W'(req_ff.slice_us) * TIME_W'(PCT_SCALE);
               div_dvs = req_ff.period_len;
               per_in = req_ff.period_len;
               st_in = S_SHARE_WAIT;
            end else begin
               st_in = S_RESP;
            end
         end
         S_SHARE_WAIT: begin
            if (div_done) begin
               if (SUM_W'(util_ff) + SUM_W'(div_quot) <= SUM_W'(limit_ff)) begin
                  unx_in = util_ff + div_quot[UTIL_W-1:0];
                  div_start = 1'b1;
                  st_in = S_BND_WAIT;
               end else begin
                  st_in = S_RESP;
               end
            end
         end
         S_BND_WAIT: begin
            if (div_done) begin
               st_in = S_BND;
            end
         end
         S_BND: begin
            // next period boundary strictly after now
            d_in = req_ff.now_us + TIME_W'(per_ff - div_rem);
            round_in = '0;
            scan_in = '0;
            clash_in = 1'b0;
            st_in = S_UNIQ;
         end
         S_UNIQ: begin
            if (scan_last) begin
               scan_in = '0;
               clash_in = 1'b0;
               if (clash_acc) begin
                  d_in = d_ff + 1'b1;
                  round_in = round_ff + 1'b1;
               end
               if (!clash_acc || round_ff == LAST_RND) begin
                  st_in = ren_ff ? S_REN_WR : S_ACT_WR;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
               clash_in = clash_acc;
            end
         end
         S_ACT_WR: begin
            wr_act = 1'b1;
            util_in = unx_ff;
            if (!any_valid || per_ff < short_ff) begin
               short_in = per_ff;
            end
            admit_in = 1'b1;
            scan_in = '0;
            bestv_in = 1'b0;
            st_in = curv_ff ? S_RESP : S_FIRST_SCAN;
         end
         S_FIRST_SCAN, S_SEL_SCAN: begin
            if (rd_valid && (st_ff == S_FIRST_SCAN || rd_budget) && (!bestv_ff || cmp_lt)) begin
               best_in = scan_ff;
               bdl_in = rd_dl;
               bestv_in = 1'b1;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_last) begin
               st_in = (st_ff == S_FIRST_SCAN) ? S_FIRST_SET : S_SEL_DONE;
            end
         end
         S_FIRST_SET: begin
            cur_in = best_ff;
            curv_in = 1'b1;
            wr_wake = 1'b1;
            st_in = S_RESP;
         end
         S_CHG_DIFF: begin
            diff_in = req_ff.now_us - rd_wake;
            if (!idle_ff && idok_ff && rd_valid && (rd_wake != '0)) begin
               st_in = S_CHG_ADD;
            end else begin
               st_in = S_REN_CHK;
            end
         end
         S_CHG_ADD: begin
            wr_used_add = 1'b1;
            st_in = S_REN_CHK;
         end
         S_REN_CHK: begin
            scan_in = '0;
            bestv_in = 1'b0;
            if (any_valid && ((req_ff.now_us - lchk_ff) >= TIME_W'(short_ff))) begin
               st_in = S_MISS_SCAN;
            end else begin
               st_in = S_SEL_SCAN;
            end
         end
         S_MISS_SCAN: begin
            pend_in[scan_ff] = rd_valid && cmp_lt;
            if (rd_valid && cmp_lt && rd_budget) begin
               miss_in = miss_ff + 1'b1;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_last) begin
               scan_in = '0;
               st_in = S_PICK_SCAN;
            end
         end
         S_PICK_SCAN: begin
            // latest expired deadline first
            if (pend_ff[scan_ff] && (!bestv_ff || cmp_lt)) begin
               best_in = scan_ff;
               bdl_in = rd_dl;
               bestv_in = 1'b1;
            end
            scan_in = scan_ff + 1'b1;
            if (scan_last) begin
               st_in = S_PICK_DONE;
            end
         end
         S_PICK_DONE: begin
            scan_in = '0;
            bestv_in = 1'b0;
            if (bestv_ff) begin
               tgt_in = best_ff;
               pend_in[best_ff] = 1'b0;
               ren_in = 1'b1;
               st_in = S_REN_START;
            end else begin
               lchk_in = req_ff.now_us;
               st_in = S_SEL_SCAN;
            end
         end
         S_REN_START: begin
            wr_used_zero = 1'b1;
            per_in = rd_period;
            div_start = 1'b1;
            div_dvs = rd_period;
            st_in = S_BND_WAIT;
         end
         S_REN_WR: begin
            wr_dl = 1'b1;
            scan_in = '0;
            bestv_in = 1'b0;
            st_in = S_PICK_SCAN;
         end
         S_SEL_DONE: begin
            if (bestv_ff) begin
               idle_in = 1'b0;
               wr_wake = 1'b1;
               cur_in = best_ff;
               curv_in = 1'b1;
               selv_in = 1'b1;
            end else begin
               idle_in = 1'b1;
            end
            st_in = S_RESP;
         end
         S_RESP: begin
            strobe_in = 1'b1;
            rsp_in.admitted = admit_ff;
            if (req_ff.opcode == OP_ACTIVATE) begin
               rsp_in.run_valid = curv_ff;
               rsp_in.run_task = ID_W'(cur_ff);
               rsp_in.switch_needed = 1'b0;
               rsp_in.missed_count = '0;
            end else begin
               rsp_in.run_valid = selv_ff;
               rsp_in.run_task = selv_ff ? ID_W'(cur_ff) : '0;
               rsp_in.switch_needed = selv_ff &&
                  (!idok_ff || (ID_W'(cur_ff) != req_ff.task_id));
               rsp_in.missed_count = (32'(miss_ff) > 15) ? MISS_OUT_W'(15)
                                                          : MISS_OUT_W'(miss_ff);
            end
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
         strobe_ff <= 1'b0;
         util_ff <= '0;
         short_ff <= '0;
         lchk_ff <= '0;
         cur_ff <= '0;
         curv_ff <= 1'b0;
         idle_ff <= 1'b0;
         limit_ff <= LIMIT_RST;
         ren_ff <= 1'b0;
         pend_ff <= '0;
      end else begin
         st_ff <= st_in;
         strobe_ff <= strobe_in;
         util_ff <= util_in;
         short_ff <= short_in;
         lchk_ff <= lchk_in;
         cur_ff <= cur_in;
         curv_ff <= curv_in;
         idle_ff <= idle_in;
         limit_ff <= limit_in;
         ren_ff <= ren_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idok_ff <= idok_in;
      tgt_ff <= tgt_in;
      scan_ff <= scan_in;
      best_ff <= best_in;
      bestv_ff <= bestv_in;
      bdl_ff <= bdl_in;
      d_ff <= d_in;
      clash_ff <= clash_in;
      round_ff <= round_in;
      miss_ff <= miss_in;
      admit_ff <= admit_in;
      diff_ff <= diff_in;
      per_ff <= per_in;
      unx_ff <= unx_in;
      selv_ff <= selv_in;
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_TASKS; i++) begin
            valid_ff[i] <= 1'b0;
            wake_ff[i] <= '0;
         end
      end else begin
         if (wr_act) begin
            valid_ff[tgt_ff] <= 1'b1;
         end
         if (wr_wake) begin
            wake_ff[best_ff] <= req_ff.now_us;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_act) begin
         period_ff[tgt_ff] <= per_ff;
         slice_ff[tgt_ff] <= req_ff.slice_us;
      end
      if (wr_act || wr_dl) begin
         dl_ff[tgt_ff] <= d_ff;
      end
      if (wr_act || wr_used_zero) begin
         used_ff[tgt_ff] <= '0;
      end else if (wr_used_add) begin
         used_ff[tgt_ff] <= rd_used + diff_ff;
      end
   end

   assign busy = st_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_data = rsp_ff;
   assign csr_ready = !busy;

`ifndef ASSERT_OFF
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while sequencer still busy");

   a_run_has_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.run_valid) |-> curv_ff)
      else $error("run reported without a current task");

   a_miss_only_tick: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.missed_count != '0) |-> !rsp_data.admitted)
      else $error("missed deadlines reported on an activate");

   a_admit_sets_valid: assert property (@(posedge clock) disable iff (reset)
      wr_act |=> valid_ff[$past(tgt_ff)])
      else $error("admitted entry not marked valid");
`endif

endmodule
`default_nettype wire

// ----- bench/edf_slice_scheduler_test.sv -----
// Testbench for the EDF slice scheduler: random and directed items checked against a predictor.
`timescale 1ns / 1ps
module edf_slice_scheduler_test;
   import edf_pkg::*;

   localparam int NTASK = MAX_TASKS_DEF;
   localparam int CYCLE_LIMIT = 6000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_type req_data = '0;
   logic rsp_strobe;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   edf_slice_scheduler i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   // scheduler image kept by the bench
   logic              tbl_valid [NTASK];
   logic [PER_W-1:0]  tbl_period [NTASK];
   logic [PER_W-1:0]  tbl_slice [NTASK];
   logic [TIME_W-1:0] tbl_deadline [NTASK];
   logic [TIME_W-1:0] tbl_used [NTASK];
   logic [TIME_W-1:0] tbl_wake [NTASK];
   longint unsigned   util_sum = 0;
   longint unsigned   util_limit = LIMIT_RST;
   logic [PER_W-1:0]  shortest_per = '0;
   logic [TIME_W-1:0] last_renew = '0;
   logic [ID_W-1:0]   cur_task = '0;
   logic              cur_valid = 1'b0;
   logic              core_idle = 1'b0;

   req_type pending_items[$];
   rsp_type expected_rsp[$];
   int unsigned sender_idle_pct = 0;
   int unsigned errors = 0;
   int unsigned cycles = 0;
   logic [TIME_W-1:0] host_us = '0;

   initial begin
      for (int i = 0; i < NTASK; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_period[i] = '0;
         tbl_slice[i] = '0;
         tbl_deadline[i] = '0;
         tbl_used[i] = '0;
         tbl_wake[i] = '0;
      end
   end

   function automatic logic [TIME_W-1:0] unique_deadline(int self, logic [TIME_W-1:0] d);
      logic clash;
      for (int round = 0; round <= NTASK; round++) begin
         clash = 1'b0;
         for (int j = 0; j < NTASK; j++)
            if (j != self && tbl_valid[j] && tbl_deadline[j] == d) clash = 1'b1;
         if (!clash) break;
         d = d + 1'b1;
      end
      return d;
   endfunction

   function automatic logic [TIME_W-1:0] period_boundary(logic [TIME_W-1:0] now,
                                                         logic [PER_W-1:0] per);
      longint unsigned n;
      n = now;
      return TIME_W'(n + (per - n % per));
   endfunction

   function automatic int earliest_task(logic need_budget);
      int best;
      best = -1;
      for (int i = 0; i < NTASK; i++) begin
         if (!tbl_valid[i]) continue;
         if (need_budget && !(tbl_used[i] < tbl_slice[i])) continue;
         if (best < 0 || tbl_deadline[i] < tbl_deadline[best]) best = i;
      end
      return best;
   endfunction

   function automatic int unsigned renew_deadlines(logic [TIME_W-1:0] now);
      logic due [NTASK];
      int unsigned missed;
      int pick;
      missed = 0;
      for (int i = 0; i < NTASK; i++) begin
         due[i] = tbl_valid[i] && tbl_deadline[i] < now;
         if (due[i] && tbl_used[i] < tbl_slice[i]) missed++;
      end
      // latest expired deadline is renewed first
      forever begin
         pick = -1;
         for (int i = 0; i < NTASK; i++)
            if (due[i] && (pick < 0 || tbl_deadline[i] > tbl_deadline[pick])) pick = i;
         if (pick < 0) break;
         due[pick] = 1'b0;
         tbl_used[pick] = '0;
         tbl_deadline[pick] = unique_deadline(pick, period_boundary(now, tbl_period[pick]));
      end
      last_renew = now;
      return missed;
   endfunction

   function automatic rsp_type predict_schedule(req_type it);
      rsp_type r;
      int t;
      int count;
      int pick;
      int unsigned m;
      longint unsigned share;
      logic [TIME_W-1:0] elapsed;
      r = '0;
      t = it.task_id;
      if (it.opcode == OP_ACTIVATE) begin
         if (!tbl_valid[t] && it.period_len != 0) begin
            share = (64'd100 * it.slice_us) / it.period_len;
            if (util_sum + share <= util_limit) begin
               count = 0;
               for (int i = 0; i < NTASK; i++) if (tbl_valid[i]) count++;
               tbl_period[t] = it.period_len;
               tbl_slice[t] = it.slice_us;
               tbl_used[t] = '0;
               tbl_deadline[t] = unique_deadline(t, period_boundary(it.now_us, it.period_len));
               tbl_valid[t] = 1'b1;
               util_sum = (util_sum + share) & 64'h3FF;
               if (count == 0 || it.period_len < shortest_per) shortest_per = it.period_len;
               r.admitted = 1'b1;
               if (!cur_valid) begin
                  pick = earliest_task(1'b0);
                  if (pick >= 0) begin
                     cur_task = ID_W'(pick);
                     cur_valid = 1'b1;
                     tbl_wake[pick] = it.now_us;
                  end
               end
            end
         end
         r.run_valid = cur_valid;
         r.run_task = cur_task;
      end else begin
         m = 0;
         if (!core_idle && tbl_valid[t] && tbl_wake[t] != 0)
            tbl_used[t] = tbl_used[t] + (it.now_us - tbl_wake[t]);
         elapsed = it.now_us - last_renew;
         if (earliest_task(1'b0) >= 0 && elapsed >= shortest_per) m = renew_deadlines(it.now_us);
         r.missed_count = (m > 15) ? 4'd15 : m[3:0];
         pick = earliest_task(1'b1);
         if (pick < 0) begin
            core_idle = 1'b1;
         end else begin
            core_idle = 1'b0;
            tbl_wake[pick] = it.now_us;
            cur_task = ID_W'(pick);
            cur_valid = 1'b1;
            r.run_valid = 1'b1;
            r.run_task = ID_W'(pick);
            r.switch_needed = (pick != t);
         end
      end
      return r;
   endfunction

   // driver: holds start until the transfer, predicts on each accepted item
   always @(posedge clock) begin
      logic launch;
      req_type nxt;
      launch = start;
      nxt = req_data;
      if (start && !busy) begin
         expected_rsp.push_back(predict_schedule(pending_items.pop_front()));
         launch = 1'b0;
      end
      if (!launch && !reset && pending_items.size() != 0 &&
          $urandom_range(99) >= sender_idle_pct) begin
         launch = 1'b1;
         nxt = pending_items[0];
      end
      start <= launch;
      req_data <= nxt;
   end

   function automatic void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_rsp.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_rsp.pop_front();
            check_field("admitted", want.admitted, rsp_data.admitted);
            check_field("run_valid", want.run_valid, rsp_data.run_valid);
            check_field("run_task", want.run_task, rsp_data.run_task);
            check_field("switch_needed", want.switch_needed, rsp_data.switch_needed);
            check_field("missed_count", want.missed_count, rsp_data.missed_count);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("edf_slice_scheduler test failed");
         $finish;
      end
   end

   function automatic req_type make_req(logic op, int id, logic [PER_W-1:0] per,
                                        logic [PER_W-1:0] slc, logic [TIME_W-1:0] now);
      req_type it;
      it.opcode = op;
      it.task_id = ID_W'(id);
      it.period_len = per;
      it.slice_us = slc;
      it.now_us = now;
      return it;
   endfunction

   function automatic req_type random_req();
      int unsigned roll;
      logic [PER_W-1:0] per;
      logic [PER_W-1:0] slc;
      roll = $urandom_range(99);
      if (roll < 3) host_us = TIME_W'({$urandom(), $urandom()});
      else if (roll < 6) host_us = host_us + $urandom();
      else host_us = host_us + $urandom_range(400);
      per = PER_W'($urandom());
      slc = PER_W'($urandom());
      if ($urandom_range(99) < 30) begin
         roll = $urandom_range(99);
         if (roll < 8) per = 0;
         else if (roll >= 20) begin
            per = PER_W'($urandom_range(2000, 10));
            slc = PER_W'($urandom_range(per / 2));
         end
         return make_req(OP_ACTIVATE, $urandom_range(NTASK - 1), per, slc, host_us);
      end
      return make_req(OP_TICK, $urandom_range(NTASK - 1), per, slc, host_us);
   endfunction

   task automatic drain();
      while (pending_items.size() != 0 || expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      while (busy) @(posedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      util_limit = value;
   endtask

   task automatic run_random(int n);
      for (int i = 0; i < n; i++) pending_items.push_back(random_req());
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      sender_idle_pct = 21;
      // directed: idle tick, bad activates, boundary clash, wrap, overrun, misses
      pending_items.push_back(make_req(OP_TICK, 0, 0, 0, 48'd10));
      pending_items.push_back(make_req(OP_ACTIVATE, 2, 0, 5, 48'd10));
      pending_items.push_back(make_req(OP_ACTIVATE, 0, 100, 20, 48'd0));
      pending_items.push_back(make_req(OP_ACTIVATE, 0, 100, 20, 48'd3));
      pending_items.push_back(make_req(OP_ACTIVATE, 1, 100, 10, 48'd5));
      pending_items.push_back(make_req(OP_ACTIVATE, 2, 1, 30'h3FFF_FFFF, 48'd6));
      pending_items.push_back(make_req(OP_ACTIVATE, 3, 30'h3FFF_FFFF, 0, 48'd7));
      pending_items.push_back(make_req(OP_TICK, 0, 0, 0, 48'd50));
      pending_items.push_back(make_req(OP_TICK, 0, 0, 0, 48'd90));
      pending_items.push_back(make_req(OP_TICK, 7, 0, 0, 48'd95));
      pending_items.push_back(make_req(OP_TICK, 1, 0, 0, 48'd150));
      pending_items.push_back(make_req(OP_ACTIVATE, 4, 1, 0, 48'd160));
      pending_items.push_back(make_req(OP_TICK, 4, 0, 0, 48'd170));
      pending_items.push_back(make_req(OP_TICK, 0, 30'h3FFF_FFFF, 30'h3FFF_FFFF, 48'd400));
      pending_items.push_back(make_req(OP_ACTIVATE, 5, 1000, 1000, 48'hFFFF_FFFF_FF00));
      pending_items.push_back(make_req(OP_ACTIVATE, 6, 1000, 9, 48'hFFFF_FFFF_FF00));
      pending_items.push_back(make_req(OP_TICK, 6, 0, 0, 48'hFFFF_FFFF_FFFF));
      pending_items.push_back(make_req(OP_TICK, 6, 0, 0, 48'd20));
      pending_items.push_back(make_req(OP_TICK, 1, 0, 0, 48'd2000));
      host_us = 48'd2000;
      drain();
      write_limit(7'd100);
      run_random(320);
      write_limit(7'd0);
      sender_idle_pct = 80;
      run_random(40);
      write_limit(7'd127);
      run_random(300);
      write_limit(7'd55);
      sender_idle_pct = 0;
      run_random(320);
      if (errors == 0) begin
         $display("edf_slice_scheduler test passed");
      end else begin
         $display("edf_slice_scheduler test failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/edf_pkg.sv
design/edf_div.sv
design/edf_slice_scheduler.sv
bench/edf_slice_scheduler_test.sv
